### rtl/core/sldd_pkg.sv
`timescale 1ns / 1ps

package sldd_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned CFG_W = 12;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned SMOOTH_DEPTH_DEF = 8;

	localparam logic [CFG_W-1:0] NOISE_FLOOR_RST = 12'd200;
	localparam logic [CFG_W-1:0] SURGE_THRESHOLD_RST = 12'd3000;
	localparam logic [CFG_W-1:0] DIRECTION_RATIO_RST = 12'd384;

	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_FLOOR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SURGE_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_RATIO = 2'd2;

	localparam logic [1:0] DIR_UNKNOWN = 2'd0;
	localparam logic [1:0] DIR_LEFT = 2'd1;
	localparam logic [1:0] DIR_RIGHT = 2'd2;
	localparam logic [1:0] DIR_CENTRE = 2'd3;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_sample;
		logic [SAMPLE_W-1:0] right_sample;
	} sample_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left_level;
		logic [SAMPLE_W-1:0] right_level;
		logic [1:0]          sound_direction;
		logic                surge_flag;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_UPDATE,
		ST_DIVIDE,
		ST_MULT,
		ST_DECIDE
	} state_t;

endpackage

### rtl/core/stereo_level_direction_detector.sv
`timescale 1ns / 1ps
// Stereo level and direction detector.
// Sample channel: sample_valid / sample_stall carry one word of a left and right
// 12-bit reading. Result channel: result_valid / result_stall carry one word of
// both smoothed levels, the direction code and the surge flag, one per sample.
// Config channel: cfg_valid / cfg_ready (always ready) writes noise floor (0),
// surge threshold (1) or direction ratio (2); other indexes are ignored.
// Write config only while no sample is in flight.
// A sample is taken in the idle state and passes through read, update, divide
// (bit-serial over sums of SUM_W = 12 + clog2(SMOOTH_DEPTH) bits), multiply
// and decide, where its result is loaded. One sample is in flight at a time;
// the next is taken in the cycle after the result is loaded, so the sample
// rate is set by the bit-serial division of the running sums by the fill count.
// Ring and running-sum update take a read-modify-write through one history
// memory with a registered read.
// The result register frees the core: a new sample is taken while an earlier
// result waits; the core holds in its final step only if that result is still
// stalled when the next one is ready.
// Reset clears sums, write slot, fill flag, state and result valid, and loads the default
// config; the history memory itself is not cleared.
module stereo_level_direction_detector
	import sldd_pkg::*;
#(
	parameter int unsigned SMOOTH_DEPTH = SMOOTH_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  sample_t              sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int unsigned SLOT_W = (SMOOTH_DEPTH > 1) ? $clog2(SMOOTH_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(SMOOTH_DEPTH + 1);
	localparam int unsigned SUM_W = SAMPLE_W + $clog2(SMOOTH_DEPTH);
	localparam int unsigned STEP_W = $clog2(SUM_W);
	localparam int unsigned PROD_W = SAMPLE_W + CFG_W;
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SMOOTH_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(SMOOTH_DEPTH);

	state_t state_q, state_d;

	logic [CFG_W-1:0] noise_floor_q, surge_threshold_q, direction_ratio_q;

	logic [2*SAMPLE_W-1:0] hist_mem [SMOOTH_DEPTH];
	logic [2*SAMPLE_W-1:0] old_pair_q;

	sample_t          sample_q;
	logic [SLOT_W-1:0] slot_q;
	logic             full_q;
	logic [SUM_W-1:0] sum_l_q, sum_r_q;
	logic [CNT_W-1:0] held_q;

	logic [SUM_W-1:0] num_l_q, num_r_q;
	logic [CNT_W-1:0] rem_l_q, rem_r_q;
	logic [STEP_W-1:0] step_q;

	logic [PROD_W-1:0] a256_q, tb_q, at_q, b256_q;

	result_t result_q;
	logic    result_valid_q;

	logic sample_take, result_free;
	logic [SLOT_W-1:0] slot_nxt;
	logic              wrap;
	logic [SUM_W-1:0] sum_l_nxt, sum_r_nxt;
	logic [SAMPLE_W-1:0] old_l, old_r;
	logic [CNT_W:0] trial_l, trial_r;
	logic           qbit_l, qbit_r;
	logic [SAMPLE_W-1:0] lvl_l, lvl_r, lvl_max, op_a, op_b;
	result_t result_nxt;

	assign cfg_ready = 1'b1;
	assign sample_stall = (state_q != ST_IDLE);
	assign sample_take = sample_valid && !sample_stall;
	assign result_free = !result_valid_q || !result_stall;
	assign result_valid = result_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (sample_take) begin
					state_d = ST_READ;
				end
			end
			ST_READ:   state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (step_q == '0) begin
					state_d = ST_MULT;
				end
			end
			ST_MULT:   state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (result_free) begin
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_floor_q <= NOISE_FLOOR_RST;
			surge_threshold_q <= SURGE_THRESHOLD_RST;
			direction_ratio_q <= DIRECTION_RATIO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_NOISE_FLOOR:     noise_floor_q <= cfg_data;
				CFG_SURGE_THRESHOLD: surge_threshold_q <= cfg_data;
				CFG_DIRECTION_RATIO: direction_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// History ring: read the entry to be replaced at accept, write the new sample in its place in update.
	always_ff @(posedge clk) begin
		if (sample_take) begin
			old_pair_q <= hist_mem[slot_q];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			hist_mem[slot_q] <= {sample_q.left_sample, sample_q.right_sample};
		end
	end

	assign old_l = old_pair_q[2*SAMPLE_W-1:SAMPLE_W];
	assign old_r = old_pair_q[SAMPLE_W-1:0];
	assign wrap = (slot_q == LAST_SLOT);
	assign slot_nxt = wrap ? '0 : slot_q + 1'b1;

	// Drop the replaced sample only once the ring has filled.
	always_comb begin
		sum_l_nxt = sum_l_q - (full_q ? SUM_W'(old_l) : '0) + SUM_W'(sample_q.left_sample);
		sum_r_nxt = sum_r_q - (full_q ? SUM_W'(old_r) : '0) + SUM_W'(sample_q.right_sample);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			full_q <= 1'b0;
			sum_l_q <= '0;
			sum_r_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			slot_q <= slot_nxt;
			full_q <= full_q || wrap;
			sum_l_q <= sum_l_nxt;
			sum_r_q <= sum_r_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_take) begin
			sample_q <= sample;
		end
	end

	// Restoring divider, one quotient bit per cycle on each channel.
	always_comb begin
		trial_l = {rem_l_q, num_l_q[SUM_W-1]};
		trial_r = {rem_r_q, num_r_q[SUM_W-1]};
		qbit_l = (trial_l >= {1'b0, held_q});
		qbit_r = (trial_r >= {1'b0, held_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			step_q <= STEP_W'(SUM_W - 1);
		end else if (state_q == ST_DIVIDE) begin
			step_q <= step_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			held_q <= (full_q || wrap) ? DEPTH_CNT : CNT_W'(slot_nxt);
			num_l_q <= sum_l_nxt;
			num_r_q <= sum_r_nxt;
			rem_l_q <= '0;
			rem_r_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			num_l_q <= {num_l_q[SUM_W-2:0], qbit_l};
			num_r_q <= {num_r_q[SUM_W-2:0], qbit_r};
			rem_l_q <= qbit_l ? CNT_W'(trial_l - {1'b0, held_q}) : trial_l[CNT_W-1:0];
			rem_r_q <= qbit_r ? CNT_W'(trial_r - {1'b0, held_q}) : trial_r[CNT_W-1:0];
		end
	end

	assign lvl_l = num_l_q[SAMPLE_W-1:0];
	assign lvl_r = num_r_q[SAMPLE_W-1:0];
	assign lvl_max = (lvl_l > lvl_r) ? lvl_l : lvl_r;

	// Treat two silent channels as an even ratio.
	always_comb begin
		if (lvl_l == '0 && lvl_r == '0) begin
			op_a = SAMPLE_W'(1);
			op_b = SAMPLE_W'(1);
		end else begin
			op_a = lvl_l;
			op_b = lvl_r;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MULT) begin
			a256_q <= PROD_W'({op_a, 8'd0});
			b256_q <= PROD_W'({op_b, 8'd0});
			tb_q <= PROD_W'(direction_ratio_q) * PROD_W'(op_b);
			at_q <= PROD_W'(op_a) * PROD_W'(direction_ratio_q);
		end
	end

	always_comb begin
		result_nxt.left_level = lvl_l;
		result_nxt.right_level = lvl_r;
		if (lvl_max < noise_floor_q) begin
			result_nxt.sound_direction = DIR_UNKNOWN;
			result_nxt.surge_flag = 1'b0;
		end else begin
			result_nxt.surge_flag = (lvl_max > surge_threshold_q);
			priority if (a256_q > tb_q) begin
				result_nxt.sound_direction = DIR_LEFT;
			end else if (at_q < b256_q) begin
				result_nxt.sound_direction = DIR_RIGHT;
			end else begin
				result_nxt.sound_direction = DIR_CENTRE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (state_q == ST_DECIDE && result_free) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	// Hold the word while stalled; load only when the register is free.
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE && result_free) begin
			result_q <= result_nxt;
		end
	end

endmodule
